### hdl/ycc2rgb_pkg.sv
// ============================================================================
// ycc2rgb_pkg
// Shared types, constants and arithmetic helpers of the YCbCr to RGB block.
// ============================================================================
package ycc2rgb_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SAMPLE_W   = 16;
   localparam int CHROMA_W   = SAMPLE_W + 1;
   localparam int COEF_W     = FRAC_BITS + 2;
   localparam int PROD_W     = COEF_W + CHROMA_W;
   localparam int GSUM_W     = PROD_W + 1;
   localparam int TERM_W     = GSUM_W - FRAC_BITS;
   localparam int SUM_W      = TERM_W + 1;

   localparam int PREC_W     = 5;
   localparam int MODE_W     = 2;
   localparam int POS_W      = 2;
   localparam int LUMA_COUNT = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Coefficients, nearest integer to c * 2^FRAC_BITS with ties rounded up
   localparam logic signed [COEF_W-1:0] K_CR_R =
      COEF_W'(((64'd1402 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic signed [COEF_W-1:0] K_CB_G =
      COEF_W'(((64'd344 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic signed [COEF_W-1:0] K_CR_G =
      COEF_W'(((64'd714 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic signed [COEF_W-1:0] K_CB_B =
      COEF_W'(((64'd1772 << FRAC_BITS) + 64'd500) / 64'd1000);

   localparam logic [GSUM_W:0] TRUNC_BIAS = (GSUM_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);

   // Chroma layouts
   localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_422 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_420 = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHROMA_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PRECISION = 2'd1;

   localparam logic [PREC_W-1:0] PRECISION_RESET = 5'd8;
   localparam logic [PREC_W-1:0] PRECISION_MIN   = 5'd1;
   localparam logic [PREC_W-1:0] PRECISION_MAX   = 5'd16;

   // Pixel positions
   localparam logic [POS_W-1:0] POS_TOP_LEFT     = 2'd0;
   localparam logic [POS_W-1:0] POS_TOP_RIGHT    = 2'd1;
   localparam logic [POS_W-1:0] POS_BOTTOM_LEFT  = 2'd2;
   localparam logic [POS_W-1:0] POS_BOTTOM_RIGHT = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] luma_top_left;
      logic [SAMPLE_W-1:0] luma_top_right;
      logic [SAMPLE_W-1:0] luma_bottom_left;
      logic [SAMPLE_W-1:0] luma_bottom_right;
      logic [SAMPLE_W-1:0] chroma_blue;
      logic [SAMPLE_W-1:0] chroma_red;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [POS_W-1:0]    pixel_position;
      logic                last_of_item;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0] chroma_mode;
      logic [PREC_W-1:0] sample_precision;
   } cfg_type;

   // One classified item as it travels from the front to the back
   typedef struct packed {
      logic [LUMA_COUNT-1:0][SAMPLE_W-1:0] luma;
      logic [CHROMA_W-1:0]                 cb_centered;
      logic [CHROMA_W-1:0]                 cr_centered;
      logic [POS_W-1:0]                    last_pos;
      logic [SAMPLE_W-1:0]                 upper;
   } job_type;

   // Divide by 2^FRAC_BITS, rounding toward zero
   function automatic logic signed [TERM_W-1:0] trunc_term(
      input logic signed [GSUM_W-1:0] v);
      logic [GSUM_W:0]        biased;
      logic signed [GSUM_W:0] shifted;
      biased  = {v[GSUM_W-1], v} + (v[GSUM_W-1] ? TRUNC_BIAS : '0);
      shifted = $signed(biased) >>> FRAC_BITS;
      return TERM_W'(shifted);
   endfunction

   // Clamp to 0 .. upper
   function automatic logic [SAMPLE_W-1:0] clamp_channel(
      input logic signed [SUM_W-1:0] s,
      input logic [SAMPLE_W-1:0]     upper);
      logic [SUM_W-1:0] upper_ext;
      upper_ext = SUM_W'(upper);
      if (s[SUM_W-1]) begin
         return '0;
      end else if (SUM_W'(s) > upper_ext) begin
         return upper;
      end else begin
         return s[SAMPLE_W-1:0];
      end
   endfunction

endpackage

### hdl/ycc2rgb_front.sv
// ============================================================================
// ycc2rgb_front
// Accepts items, resolves the chroma layout and precision, centers chroma.
// ============================================================================
module ycc2rgb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ycc2rgb_pkg::req_type  req_data,
   input  ycc2rgb_pkg::cfg_type  cfg,
   output logic                  push,
   output ycc2rgb_pkg::job_type  push_job,
   input  logic                  queue_full
);

   logic                 f_valid_ff, f_valid_in;
   ycc2rgb_pkg::job_type f_job_ff, f_job_in;
   logic                 accept;

   logic [ycc2rgb_pkg::PREC_W-1:0]   prec_eff;
   logic [ycc2rgb_pkg::CHROMA_W-1:0] scale;
   logic [ycc2rgb_pkg::CHROMA_W-1:0] offset;

   assign busy   = f_valid_ff && queue_full;
   assign accept = start && !busy;
   assign push   = f_valid_ff && !queue_full;
   assign push_job = f_job_ff;

   always_comb begin
      if (cfg.sample_precision < ycc2rgb_pkg::PRECISION_MIN) begin
         prec_eff = ycc2rgb_pkg::PRECISION_MIN;
      end else if (cfg.sample_precision > ycc2rgb_pkg::PRECISION_MAX) begin
         prec_eff = ycc2rgb_pkg::PRECISION_MAX;
      end else begin
         prec_eff = cfg.sample_precision;
      end
      scale  = ycc2rgb_pkg::CHROMA_W'(1) << prec_eff;
      offset = scale >> 1;

      f_job_in.luma[0] = req_data.luma_top_left;
      f_job_in.luma[1] = req_data.luma_top_right;
      f_job_in.luma[2] = req_data.luma_bottom_left;
      f_job_in.luma[3] = req_data.luma_bottom_right;
      f_job_in.cb_centered = {1'b0, req_data.chroma_blue} - offset;
      f_job_in.cr_centered = {1'b0, req_data.chroma_red} - offset;
      f_job_in.upper = ycc2rgb_pkg::SAMPLE_W'(scale - ycc2rgb_pkg::CHROMA_W'(1));
      case (cfg.chroma_mode)
         ycc2rgb_pkg::MODE_422: f_job_in.last_pos = ycc2rgb_pkg::POS_TOP_RIGHT;
         ycc2rgb_pkg::MODE_420: f_job_in.last_pos = ycc2rgb_pkg::POS_BOTTOM_RIGHT;
         default:               f_job_in.last_pos = ycc2rgb_pkg::POS_TOP_LEFT;
      endcase
   end

   always_comb begin
      if (accept) begin
         f_valid_in = 1'b1;
      end else if (push) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_job_ff <= f_job_in;
      end
   end

   a_busy_holds_item: assert property (@(posedge clock) disable iff (reset)
      busy |=> f_valid_ff)
      else $error("front dropped a held item while busy");

endmodule

### hdl/ycc2rgb_queue.sv
// ============================================================================
// ycc2rgb_queue
// Short FIFO of classified items between the front and the back.
// ============================================================================
module ycc2rgb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ycc2rgb_pkg::job_type  push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ycc2rgb_pkg::job_type  head_job
);

   ycc2rgb_pkg::job_type mem_ff [ycc2rgb_pkg::QUEUE_DEPTH];

   logic [ycc2rgb_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ycc2rgb_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ycc2rgb_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [ycc2rgb_pkg::QPTR_W-1:0] PTR_LAST =
      ycc2rgb_pkg::QPTR_W'(ycc2rgb_pkg::QUEUE_DEPTH - 1);
   localparam logic [ycc2rgb_pkg::QCNT_W-1:0] COUNT_FULL =
      ycc2rgb_pkg::QCNT_W'(ycc2rgb_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == COUNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

### hdl/ycc2rgb_back.sv
// ============================================================================
// ycc2rgb_back
// Chroma products per item, then one clamped pixel per cycle to the output.
// ============================================================================
module ycc2rgb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ycc2rgb_pkg::job_type  head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   output ycc2rgb_pkg::rsp_type  rsp_data
);

   // product stage
   logic                                         p_valid_ff, p_valid_in;
   logic signed [ycc2rgb_pkg::PROD_W-1:0]        p_r_ff, p_gb_ff, p_gr_ff, p_b_ff;
   logic signed [ycc2rgb_pkg::PROD_W-1:0]        p_r_in, p_gb_in, p_gr_in, p_b_in;
   logic [ycc2rgb_pkg::LUMA_COUNT-1:0][ycc2rgb_pkg::SAMPLE_W-1:0] p_luma_ff;
   logic [ycc2rgb_pkg::POS_W-1:0]                p_last_ff;
   logic [ycc2rgb_pkg::SAMPLE_W-1:0]             p_upper_ff;
   logic signed [ycc2rgb_pkg::CHROMA_W-1:0]      cbc, crc;

   // pixel stage
   logic                                         t_valid_ff, t_valid_in;
   logic signed [ycc2rgb_pkg::TERM_W-1:0]        t_r_ff, t_g_ff, t_b_ff;
   logic signed [ycc2rgb_pkg::TERM_W-1:0]        t_r_in, t_g_in, t_b_in;
   logic [ycc2rgb_pkg::LUMA_COUNT-1:0][ycc2rgb_pkg::SAMPLE_W-1:0] t_luma_ff;
   logic [ycc2rgb_pkg::POS_W-1:0]                t_last_ff;
   logic [ycc2rgb_pkg::SAMPLE_W-1:0]             t_upper_ff;
   logic [ycc2rgb_pkg::POS_W-1:0]                t_pos_ff, t_pos_in;
   logic signed [ycc2rgb_pkg::GSUM_W-1:0]        g_sum;

   logic                                         t_done, t_free, p_adv;
   logic [ycc2rgb_pkg::SAMPLE_W-1:0]             y;
   logic signed [ycc2rgb_pkg::SUM_W-1:0]         y_ext, r_sum, g_sum_pix, b_sum;

   logic                                         rsp_valid_ff;
   ycc2rgb_pkg::rsp_type                         rsp_ff, rsp_in;

   assign t_done = t_valid_ff && (t_pos_ff == t_last_ff);
   assign t_free = !t_valid_ff || t_done;
   assign p_adv  = p_valid_ff && t_free;
   assign pop    = head_valid && (!p_valid_ff || p_adv);

   assign cbc = $signed(head_job.cb_centered);
   assign crc = $signed(head_job.cr_centered);

   always_comb begin
      p_r_in  = ycc2rgb_pkg::K_CR_R * crc;
      p_gb_in = ycc2rgb_pkg::K_CB_G * cbc;
      p_gr_in = ycc2rgb_pkg::K_CR_G * crc;
      p_b_in  = ycc2rgb_pkg::K_CB_B * cbc;
   end

   // G sums both products at full precision before truncation
   always_comb begin
      g_sum  = ycc2rgb_pkg::GSUM_W'(p_gb_ff) + ycc2rgb_pkg::GSUM_W'(p_gr_ff);
      t_r_in = ycc2rgb_pkg::trunc_term(ycc2rgb_pkg::GSUM_W'(p_r_ff));
      t_g_in = ycc2rgb_pkg::trunc_term(g_sum);
      t_b_in = ycc2rgb_pkg::trunc_term(ycc2rgb_pkg::GSUM_W'(p_b_ff));
   end

   always_comb begin
      if (pop) begin
         p_valid_in = 1'b1;
      end else if (p_adv) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end

      if (p_adv) begin
         t_valid_in = 1'b1;
      end else if (t_done) begin
         t_valid_in = 1'b0;
      end else begin
         t_valid_in = t_valid_ff;
      end

      if (t_done || !t_valid_ff) begin
         t_pos_in = ycc2rgb_pkg::POS_TOP_LEFT;
      end else begin
         t_pos_in = t_pos_ff + 1'b1;
      end
   end

   // Pixel arithmetic for the current position
   always_comb begin
      y         = t_luma_ff[t_pos_ff];
      y_ext     = $signed({{(ycc2rgb_pkg::SUM_W - ycc2rgb_pkg::SAMPLE_W){1'b0}}, y});
      r_sum     = y_ext + ycc2rgb_pkg::SUM_W'(t_r_ff);
      g_sum_pix = y_ext - ycc2rgb_pkg::SUM_W'(t_g_ff);
      b_sum     = y_ext + ycc2rgb_pkg::SUM_W'(t_b_ff);

      rsp_in.red            = ycc2rgb_pkg::clamp_channel(r_sum, t_upper_ff);
      rsp_in.green          = ycc2rgb_pkg::clamp_channel(g_sum_pix, t_upper_ff);
      rsp_in.blue           = ycc2rgb_pkg::clamp_channel(b_sum, t_upper_ff);
      rsp_in.pixel_position = t_pos_ff;
      rsp_in.last_of_item   = (t_pos_ff == t_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         t_valid_ff   <= 1'b0;
         t_pos_ff     <= ycc2rgb_pkg::POS_TOP_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         t_valid_ff   <= t_valid_in;
         t_pos_ff     <= t_pos_in;
         rsp_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_r_ff     <= p_r_in;
         p_gb_ff    <= p_gb_in;
         p_gr_ff    <= p_gr_in;
         p_b_ff     <= p_b_in;
         p_luma_ff  <= head_job.luma;
         p_last_ff  <= head_job.last_pos;
         p_upper_ff <= head_job.upper;
      end
      if (p_adv) begin
         t_r_ff     <= t_r_in;
         t_g_ff     <= t_g_in;
         t_b_ff     <= t_b_in;
         t_luma_ff  <= p_luma_ff;
         t_last_ff  <= p_last_ff;
         t_upper_ff <= p_upper_ff;
      end
      if (t_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_of_item |->
         (rsp_ff.pixel_position == ycc2rgb_pkg::POS_TOP_LEFT) ||
         (rsp_ff.pixel_position == ycc2rgb_pkg::POS_TOP_RIGHT) ||
         (rsp_ff.pixel_position == ycc2rgb_pkg::POS_BOTTOM_RIGHT))
      else $error("item ended on an impossible pixel position");

   a_pixels_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_of_item |=>
         rsp_valid_ff && (rsp_ff.pixel_position == $past(rsp_ff.pixel_position) + 2'd1))
      else $error("pixels of one item not emitted back to back");

endmodule

### hdl/ycbcr_to_rgb_subsampled.sv
// ============================================================================
// ycbcr_to_rgb_subsampled
// YCbCr to RGB conversion for 4:4:4, 4:2:2 and 4:2:0 items, 1..16 bit samples.
// ============================================================================
//
//   channel   ports                          handshake
//   -------   ----------------------------   ----------------------------------
//   request   start, busy, req_data          word taken when start && !busy
//   response  rsp_valid, rsp_data            one word per strobe, no stall
//   config    csr_valid, csr_ready,          write when csr_valid && csr_ready
//             csr_index, csr_data            (csr_ready is always high)
//
// An item yields 1, 2 or 4 pixels for 4:4:4, 4:2:2 or 4:2:0, and the pixel
// stage emits one pixel per cycle; a new item can be taken every cycle while
// the queue has room. The first pixel reaches the result ports through the
// front register (loaded at the edge that takes the item), queue, product
// register, pixel register and output register, in that order.
// Reset is synchronous and clears all valid flags and the queue; registers
// return to 4:4:4 and 8-bit precision. The receiver cannot stall; busy rises
// only when the front holds an item and the queue is full.
//
module ycbcr_to_rgb_subsampled (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   start,
   output logic                                   busy,
   input  ycc2rgb_pkg::req_type                   req_data,

   output logic                                   rsp_valid,
   output ycc2rgb_pkg::rsp_type                   rsp_data,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ycc2rgb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ycc2rgb_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers
   ycc2rgb_pkg::cfg_type cfg_ff, cfg_in;
   logic                 csr_write;

   // Front to queue, queue to back
   logic                 push;
   ycc2rgb_pkg::job_type push_job;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;
   ycc2rgb_pkg::job_type head_job;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Write the addressed register; drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ycc2rgb_pkg::CSR_CHROMA_MODE: begin
               cfg_in.chroma_mode = csr_data[ycc2rgb_pkg::MODE_W-1:0];
            end
            ycc2rgb_pkg::CSR_SAMPLE_PRECISION: begin
               cfg_in.sample_precision = csr_data[ycc2rgb_pkg::PREC_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chroma_mode      <= ycc2rgb_pkg::MODE_444;
         cfg_ff.sample_precision <= ycc2rgb_pkg::PRECISION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept and classify
   ycc2rgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // Decouple front and back
   ycc2rgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Multiply, truncate, add luma, clamp, emit
   ycc2rgb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
